/* sv/ffa_pkg.sv */
// Shared types and codes for the first-fit heap allocator.
package ffa_pkg;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_HEAD,
    S_A_WAIT,
    S_A_WR1,
    S_A_WR2,
    S_A_WR3,
    S_F_HEAD,
    S_F_WAIT,
    S_F_RDB,
    S_F_RDC,
    S_F_MRG,
    S_F_WR1,
    S_F_WR2,
    S_RESP
  } state_t;

  typedef logic [1:0] status_t;

  localparam status_t ST_ALLOC   = 2'd0;
  localparam status_t ST_OOM     = 2'd1;
  localparam status_t ST_FREED   = 2'd2;
  localparam status_t ST_IGNORED = 2'd3;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

endpackage

/* sv/ffa_store.sv */
// Header store: block size and next-free link per header offset, one read port.
module ffa_store #(
  parameter int AW = 9
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [AW-1:0] rd_size,
  output logic [AW:0]   rd_next,
  input  logic          size_we,
  input  logic [AW-1:0] size_addr,
  input  logic [AW-1:0] size_data,
  input  logic          next_we,
  input  logic [AW-1:0] next_addr,
  input  logic [AW:0]   next_data
);

  logic [AW-1:0] size_mem [2**AW];
  logic [AW:0]   next_mem [2**AW];

  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[size_addr] <= size_data;
    end
    rd_size <= size_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_addr] <= next_data;
    end
    rd_next <= next_mem[rd_addr];
  end

endmodule

/* sv/first_fit_heap_allocator.sv */
// Top level: first-fit heap allocator over an address-ordered free list.
// An allocate walks the free list from its head a block at a time, then writes in
// S_A_WR1, S_A_WR2 and S_A_WR3. A free walks the blocks before it, then reads and writes
// in S_F_RDB, S_F_RDC, S_F_MRG, S_F_WR1 and S_F_WR2; an ignored free goes from idle
// straight to the response. Every walk stops after HEAP_BYTES blocks. One transaction
// is in flight at a time; one header read per cycle. Reset: a clearing pass
// initializes the header store; no input transaction is accepted until it completes.
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = 512,
  parameter int HEADER_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [9:0] request_size,
  input  logic [8:0] payload_addr,
  input  logic       pointer_is_null,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [8:0] granted_addr,
  output logic       was_split,
  output logic       merged_before,
  output logic       merged_after
);

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int LW = AW + 1;
  localparam int WW = ((AW > 10) ? AW : 10) + 2;
  localparam logic [LW-1:0] NONE_L = LW'(HEAP_BYTES);
  localparam logic [WW-1:0] HEAP_W = WW'(HEAP_BYTES);
  localparam logic [WW-1:0] HDR_W  = WW'(HEADER_BYTES);
  localparam logic [AW-1:0] LAST_A = AW'(HEAP_BYTES - 1);
  localparam logic [AW-1:0] INIT_SZ = AW'(HEAP_BYTES - HEADER_BYTES);

  function automatic logic [LW-1:0] clean(input logic [LW-1:0] v);
    clean = (v >= NONE_L) ? NONE_L : v;
  endfunction

  function automatic logic [AW-1:0] sat(input logic [WW-1:0] v);
    sat = (v > WW'(HEAP_BYTES - 1)) ? LAST_A : v[AW-1:0];
  endfunction

  ffa_pkg::state_t state, state_next;

  logic [AW-1:0] clr;
  logic [LW-1:0] head, cur, prev, steps, nx, nlink;
  logic [9:0]    req;
  logic [AW-1:0] sz, nb, psz, blk, b2, bs2, nsz;
  logic          split, mb, ma;
  ffa_pkg::status_t r_status;
  logic [8:0]    r_grant;

  logic [AW-1:0] rd_addr, rd_size, size_addr, size_data, next_addr;
  logic [LW-1:0] rd_next, next_data, rd_nx;
  logic          size_we, next_we;

  logic          fit, split_c, f_cont, unplace, mb_c, ma_c, resp_load;
  logic [WW-1:0] sub_w, nb_w, rel_w;
  logic [LW-1:0] steps_inc, succ;
  logic [AW-1:0] bs2_c, nsz_c;

  ffa_store #(.AW(AW)) u_store (
    .clk       (clk),
    .rd_addr   (rd_addr),
    .rd_size   (rd_size),
    .rd_next   (rd_next),
    .size_we   (size_we),
    .size_addr (size_addr),
    .size_data (size_data),
    .next_we   (next_we),
    .next_addr (next_addr),
    .next_data (next_data)
  );

  assign rd_nx     = clean(rd_next);
  assign steps_inc = steps + LW'(1);
  assign fit       = WW'(rd_size) >= WW'(req);
  assign sub_w     = WW'(rd_size) - WW'(req);
  assign nb_w      = WW'(cur) + HDR_W + WW'(req);
  assign split_c   = fit && (sub_w > HDR_W) && (nb_w < HEAP_W);
  assign f_cont    = (rd_nx != NONE_L) && (rd_nx < {1'b0, blk});
  assign rel_w     = WW'(payload_addr) - HDR_W;
  assign unplace   = (WW'(payload_addr) < HDR_W) || (rel_w >= HEAP_W);
  assign mb_c      = (prev != NONE_L) && (WW'(prev) + HDR_W + WW'(psz) == WW'(blk));
  assign bs2_c     = mb_c ? sat(WW'(psz) + HDR_W + WW'(rd_size)) : rd_size;
  assign ma_c      = (cur != NONE_L) && (WW'(b2) + HDR_W + WW'(bs2) == WW'(cur));
  assign nsz_c     = ma_c ? sat(WW'(bs2) + HDR_W + WW'(rd_size)) : bs2;
  assign succ      = split ? {1'b0, nb} : nx;
  assign resp_load = (state == ffa_pkg::S_RESP) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffa_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_addr    = cur[AW-1:0];
    size_we    = 1'b0;
    size_addr  = clr;
    size_data  = '0;
    next_we    = 1'b0;
    next_addr  = clr;
    next_data  = '0;
    case (state)
      ffa_pkg::S_CLEAR: begin
        size_we   = 1'b1;
        next_we   = 1'b1;
        size_data = (clr == '0) ? INIT_SZ : '0;
        next_data = (clr == '0) ? NONE_L : '0;
        if (clr == LAST_A) begin
          state_next = ffa_pkg::S_IDLE;
        end
      end
      ffa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (action == ffa_pkg::ACT_ALLOC) begin
            state_next = ffa_pkg::S_A_HEAD;
          end else if (pointer_is_null || unplace) begin
            state_next = ffa_pkg::S_RESP;
          end else begin
            state_next = ffa_pkg::S_F_HEAD;
          end
        end
      end
      ffa_pkg::S_A_HEAD: begin
        state_next = (cur == NONE_L) ? ffa_pkg::S_RESP : ffa_pkg::S_A_WAIT;
      end
      ffa_pkg::S_A_WAIT: begin
        rd_addr = rd_nx[AW-1:0];
        if (fit) begin
          state_next = ffa_pkg::S_A_WR1;
        end else if (rd_nx == NONE_L || steps_inc >= NONE_L) begin
          state_next = ffa_pkg::S_RESP;
        end
      end
      ffa_pkg::S_A_WR1: begin
        size_we    = split;
        next_we    = split;
        size_addr  = nb;
        next_addr  = nb;
        size_data  = sat(WW'(sz) - WW'(req) - HDR_W);
        next_data  = nx;
        state_next = ffa_pkg::S_A_WR2;
      end
      ffa_pkg::S_A_WR2: begin
        size_we    = split;
        next_we    = split;
        size_addr  = cur[AW-1:0];
        next_addr  = cur[AW-1:0];
        size_data  = req[AW-1:0];
        next_data  = {1'b0, nb};
        state_next = ffa_pkg::S_A_WR3;
      end
      ffa_pkg::S_A_WR3: begin
        next_we    = (prev != NONE_L);
        next_addr  = prev[AW-1:0];
        next_data  = succ;
        state_next = ffa_pkg::S_RESP;
      end
      ffa_pkg::S_F_HEAD: begin
        if (cur != NONE_L && cur < {1'b0, blk}) begin
          state_next = ffa_pkg::S_F_WAIT;
        end else begin
          state_next = ffa_pkg::S_F_RDB;
        end
      end
      ffa_pkg::S_F_WAIT: begin
        rd_addr = rd_nx[AW-1:0];
        if (!f_cont || steps_inc >= NONE_L) begin
          state_next = ffa_pkg::S_F_RDB;
        end
      end
      ffa_pkg::S_F_RDB: begin
        rd_addr    = blk;
        state_next = ffa_pkg::S_F_RDC;
      end
      ffa_pkg::S_F_RDC: begin
        state_next = ffa_pkg::S_F_MRG;
      end
      ffa_pkg::S_F_MRG: begin
        state_next = ffa_pkg::S_F_WR1;
      end
      ffa_pkg::S_F_WR1: begin
        size_we    = mb || ma;
        size_addr  = b2;
        size_data  = nsz;
        next_we    = 1'b1;
        next_addr  = b2;
        next_data  = nlink;
        state_next = ffa_pkg::S_F_WR2;
      end
      ffa_pkg::S_F_WR2: begin
        next_we    = (prev != NONE_L) && !mb;
        next_addr  = prev[AW-1:0];
        next_data  = {1'b0, b2};
        state_next = ffa_pkg::S_RESP;
      end
      ffa_pkg::S_RESP: begin
        if (!out_valid || out_ready) begin
          state_next = ffa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ffa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr  <= '0;
      head <= '0;
    end else begin
      case (state)
        ffa_pkg::S_CLEAR: begin
          clr <= clr + AW'(1);
        end
        ffa_pkg::S_A_WR3: begin
          if (prev == NONE_L) begin
            head <= succ;
          end
        end
        ffa_pkg::S_F_WR2: begin
          if (prev == NONE_L) begin
            head <= {1'b0, b2};
          end
        end
        default: begin
          clr <= clr;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ffa_pkg::S_IDLE: begin
        req      <= request_size;
        blk      <= rel_w[AW-1:0];
        cur      <= clean(head);
        prev     <= NONE_L;
        steps    <= '0;
        r_grant  <= '0;
        split    <= 1'b0;
        mb       <= 1'b0;
        ma       <= 1'b0;
        r_status <= (action == ffa_pkg::ACT_ALLOC) ? ffa_pkg::ST_OOM : ffa_pkg::ST_IGNORED;
      end
      ffa_pkg::S_A_WAIT: begin
        sz    <= rd_size;
        nx    <= rd_nx;
        split <= split_c;
        nb    <= nb_w[AW-1:0];
        if (!fit) begin
          prev  <= cur;
          cur   <= rd_nx;
          steps <= steps_inc;
        end
      end
      ffa_pkg::S_A_WR3: begin
        r_status <= ffa_pkg::ST_ALLOC;
        r_grant  <= 9'(WW'(cur) + HDR_W);
      end
      ffa_pkg::S_F_WAIT: begin
        prev  <= cur;
        psz   <= rd_size;
        steps <= steps_inc;
        cur   <= (f_cont && steps_inc >= NONE_L) ? NONE_L : rd_nx;
      end
      ffa_pkg::S_F_RDC: begin
        mb  <= mb_c;
        b2  <= mb_c ? prev[AW-1:0] : blk;
        bs2 <= bs2_c;
      end
      ffa_pkg::S_F_MRG: begin
        ma    <= ma_c;
        nsz   <= nsz_c;
        nlink <= ma_c ? rd_nx : cur;
      end
      ffa_pkg::S_F_WR2: begin
        r_status <= ffa_pkg::ST_FREED;
      end
      default: begin
        req <= req;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (resp_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_load) begin
      status        <= r_status;
      granted_addr  <= r_grant;
      was_split     <= split && (r_status == ffa_pkg::ST_ALLOC);
      merged_before <= mb && (r_status == ffa_pkg::ST_FREED);
      merged_after  <= ma && (r_status == ffa_pkg::ST_FREED);
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ffa_pkg::S_CLEAR) |-> !in_ready)
    else $error("input accepted during clearing pass");

  a_head_in_range: assert property (@(posedge clk) disable iff (rst)
    head <= NONE_L)
    else $error("free list head out of range");

  a_alloc_no_merge: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ffa_pkg::ST_ALLOC) |-> (!merged_before && !merged_after))
    else $error("merge flag on an allocate result");

  a_grant_only_alloc: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ffa_pkg::ST_ALLOC) |-> (granted_addr == '0 && !was_split))
    else $error("grant fields set on a non-allocate result");

endmodule

/* tb/first_fit_heap_allocator_tb.sv */
// Self-checking testbench for the first-fit heap allocator: directed and random transactions.
module first_fit_heap_allocator_tb;

  localparam int HEAP = 512;
  localparam int HDR  = 16;
  localparam int NONE = HEAP;

  typedef struct packed {
    ffa_pkg::status_t status;
    logic [8:0]       addr;
    logic             split;
    logic             mb;
    logic             ma;
  } alloc_result_t;

  logic             clk, rst;
  logic             in_valid, in_ready;
  logic             action;
  logic [9:0]       request_size;
  logic [8:0]       payload_addr;
  logic             pointer_is_null;
  logic             out_valid, out_ready;
  ffa_pkg::status_t status;
  logic [8:0]       granted_addr;
  logic             was_split, merged_before, merged_after;

  first_fit_heap_allocator dut (.*);

  int heap_size[HEAP];
  int heap_next[HEAP];
  int heap_head;
  alloc_result_t pending_results[$];
  logic [8:0]    live_blocks[$];
  int errors, sent, checked, idle_max;
  int n_alloc, n_oom, n_freed, n_ignored, n_split, n_mb, n_ma;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int clean_link(int v);
    return (v >= HEAP) ? NONE : v;
  endfunction
  function automatic int size_of(int off);
    return (off < HEAP) ? heap_size[off] : 0;
  endfunction
  function automatic int next_of(int off);
    return (off < HEAP) ? clean_link(heap_next[off]) : NONE;
  endfunction
  function automatic void put_size(int off, int v);
    if (off < HEAP) heap_size[off] = (v > HEAP - 1) ? HEAP - 1 : v;
  endfunction
  function automatic void put_next(int off, int v);
    if (off < HEAP) heap_next[off] = clean_link(v);
  endfunction

  function automatic void heap_reset();
    foreach (heap_size[i]) begin
      heap_size[i] = 0;
      heap_next[i] = 0;
    end
    heap_size[0] = HEAP - HDR;
    heap_next[0] = NONE;
    heap_head = 0;
  endfunction

  function automatic alloc_result_t heap_allocate(int req);
    alloc_result_t r;
    int prev, cur, steps, sz, nb;
    r = '0;
    r.status = ffa_pkg::ST_OOM;
    prev = NONE;
    cur = clean_link(heap_head);
    steps = 0;
    while (cur != NONE && steps < HEAP) begin
      sz = size_of(cur);
      if (sz >= req) begin
        if (sz - req > HDR) begin
          nb = cur + HDR + req;
          if (nb < HEAP) begin
            put_size(nb, sz - req - HDR);
            put_next(nb, next_of(cur));
            put_size(cur, req);
            put_next(cur, nb);
            r.split = 1;
          end
        end
        if (prev == NONE) heap_head = next_of(cur);
        else put_next(prev, next_of(cur));
        r.status = ffa_pkg::ST_ALLOC;
        r.addr = 9'((cur + HDR) & 'h1FF);
        return r;
      end
      prev = cur;
      cur = next_of(cur);
      steps++;
    end
    return r;
  endfunction

  function automatic alloc_result_t heap_release(int addr);
    alloc_result_t r;
    int blk, prev, cur, steps;
    r = '0;
    if (addr < HDR || addr - HDR >= HEAP) begin
      r.status = ffa_pkg::ST_IGNORED;
      return r;
    end
    blk = addr - HDR;
    prev = NONE;
    cur = clean_link(heap_head);
    steps = 0;
    while (cur != NONE && cur < blk) begin
      if (steps >= HEAP) begin
        cur = NONE;
        break;
      end
      prev = cur;
      cur = next_of(cur);
      steps++;
    end
    if (prev != NONE && prev + HDR + size_of(prev) == blk) begin
      put_size(prev, size_of(prev) + HDR + size_of(blk));
      blk = prev;
      r.mb = 1;
    end
    if (cur != NONE && blk + HDR + size_of(blk) == cur) begin
      put_size(blk, size_of(blk) + HDR + size_of(cur));
      put_next(blk, next_of(cur));
      r.ma = 1;
    end else begin
      put_next(blk, cur);
    end
    if (prev == NONE) heap_head = blk;
    else if (prev != blk) put_next(prev, blk);
    r.status = ffa_pkg::ST_FREED;
    return r;
  endfunction

  task automatic send_item(logic act, logic [9:0] req, logic [8:0] addr, logic nul);
    int gap;
    alloc_result_t r;
    gap = $urandom_range(idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    action          <= act;
    request_size    <= req;
    payload_addr    <= addr;
    pointer_is_null <= nul;
    do @(posedge clk); while (!in_ready);
    if (act == ffa_pkg::ACT_ALLOC) r = heap_allocate(int'(req));
    else if (nul) r = '{status: ffa_pkg::ST_IGNORED, default: '0};
    else r = heap_release(int'(addr));
    if (r.status == ffa_pkg::ST_ALLOC) live_blocks.push_back(r.addr);
    pending_results.push_back(r);
    sent++;
  endtask

  task automatic free_live(int idx);
    logic [8:0] a;
    a = live_blocks[idx];
    live_blocks.delete(idx);
    send_item(ffa_pkg::ACT_FREE, 10'($urandom), a, 1'b0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_alloc_extremes();
    send_item(ffa_pkg::ACT_ALLOC, 10'd1023, 9'd0, 1'b0);
    send_item(ffa_pkg::ACT_ALLOC, 10'd512, 9'd0, 1'b0);
    send_item(ffa_pkg::ACT_ALLOC, 10'd497, 9'd0, 1'b0);
    send_item(ffa_pkg::ACT_ALLOC, 10'd0, 9'd0, 1'b0);
    send_item(ffa_pkg::ACT_ALLOC, 10'd40, 9'd0, 1'b0);
    send_item(ffa_pkg::ACT_ALLOC, 10'd24, 9'd0, 1'b0);
    send_item(ffa_pkg::ACT_ALLOC, 10'd100, 9'd0, 1'b0);
  endtask

  task automatic test_merge_paths();
    free_live(2);
    free_live(1);
    free_live(1);
    free_live(0);
    send_item(ffa_pkg::ACT_ALLOC, 10'd496, 9'd0, 1'b0);
    send_item(ffa_pkg::ACT_ALLOC, 10'd0, 9'd0, 1'b0);
    free_live(0);
    send_item(ffa_pkg::ACT_ALLOC, 10'd490, 9'd0, 1'b0);
    free_live(0);
  endtask

  task automatic test_ignored_frees();
    send_item(ffa_pkg::ACT_FREE, 10'h3FF, 9'h1FF, 1'b1);
    send_item(ffa_pkg::ACT_FREE, 10'h000, 9'd0, 1'b0);
    send_item(ffa_pkg::ACT_FREE, 10'h2AA, 9'd15, 1'b0);
    send_item(ffa_pkg::ACT_FREE, 10'h155, 9'd7, 1'b1);
  endtask

  task automatic test_random_traffic(int count);
    int sel;
    repeat (count) begin
      if ($urandom_range(99) < 5) idle_max = (idle_max == 0) ? 11 : 0;
      if ($urandom_range(199) == 0) wait_drained();
      sel = $urandom_range(99);
      if (sel < 48) begin
        if ($urandom_range(19) == 0)
          send_item(ffa_pkg::ACT_ALLOC, 10'($urandom), 9'($urandom), 1'($urandom));
        else
          send_item(ffa_pkg::ACT_ALLOC, 10'($urandom_range(64)), 9'($urandom), 1'($urandom));
      end else if (sel < 88 && live_blocks.size() > 0) begin
        free_live($urandom_range(live_blocks.size() - 1));
      end else if (sel < 94) begin
        send_item(ffa_pkg::ACT_FREE, 10'($urandom), 9'($urandom), 1'b1);
      end else begin
        send_item(ffa_pkg::ACT_FREE, 10'($urandom), 9'($urandom_range(15)), 1'b0);
      end
    end
  endtask

  task automatic test_invalid_frees();
    repeat (30) begin
      if ($urandom_range(1))
        send_item(ffa_pkg::ACT_FREE, 10'($urandom), 9'($urandom_range(511, 16)), 1'b0);
      else
        send_item(ffa_pkg::ACT_ALLOC, 10'($urandom_range(128)), 9'($urandom), 1'b0);
    end
    send_item(ffa_pkg::ACT_FREE, 10'd0, 9'd511, 1'b0);
  endtask

  initial begin
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      int stall;
      stall = $urandom_range(idle_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      alloc_result_t e, a;
      a = '{status, granted_addr, was_split, merged_before, merged_after};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction, actual %p", $time, a);
        errors++;
      end else begin
        e = pending_results.pop_front();
        checked++;
        if (a != e) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, a);
          errors++;
        end
        case (e.status)
          ffa_pkg::ST_ALLOC: n_alloc++;
          ffa_pkg::ST_OOM:   n_oom++;
          ffa_pkg::ST_FREED: n_freed++;
          default:           n_ignored++;
        endcase
        n_split += e.split;
        n_mb += e.mb;
        n_ma += e.ma;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    action <= ffa_pkg::ACT_ALLOC;
    request_size <= '0;
    payload_addr <= '0;
    pointer_is_null <= 1'b0;
    idle_max = 11;
    heap_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_alloc_extremes();
    test_merge_paths();
    test_ignored_frees();
    wait_drained();
    test_random_traffic(1050);
    wait_drained();
    test_invalid_frees();
    wait_drained();
    repeat (600) @(posedge clk);
    $display("Covered %0d transactions: %0d allocated, %0d out of memory, %0d freed, %0d ignored",
             checked, n_alloc, n_oom, n_freed, n_ignored);
    $display("Splits %0d, merges with preceding %0d, with following %0d, errors %0d",
             n_split, n_mb, n_ma, errors);
    if (errors == 0 && pending_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
sv/ffa_pkg.sv
sv/ffa_store.sv
sv/first_fit_heap_allocator.sv
tb/first_fit_heap_allocator_tb.sv
